// File: hw/rtl/tpdh_pkg.sv
// Package with shared constants of the pair distance histogram.
package tpdh_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdRun   = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] RegLenX     = 3'd0;
  localparam logic [2:0] RegLenY     = 3'd1;
  localparam logic [2:0] RegLenZ     = 3'd2;
  localparam logic [2:0] RegTiltXy   = 3'd3;
  localparam logic [2:0] RegTiltXz   = 3'd4;
  localparam logic [2:0] RegTiltYz   = 3'd5;
  localparam logic [2:0] RegNumAtoms = 3'd6;
  localparam logic [2:0] RegBinScale = 3'd7;

  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

endpackage

// File: hw/rtl/triclinic_pair_distance_histogram.sv
// Top level of the triclinic pair distance histogram.
//
// Items arrive on the in channel (cmd and fields) with valid/ready.
// A load writes one atom position into the position memories. A clear
// sweeps the histogram memory, one bin a cycle. A read gives one result.
// A run walks every pair i < j < num_atoms; each pair goes through one
// shared sequencer: memory reads, wrap and tilt corrections, squaring on one
// 32x32 multiplier (three words, four partial products each), a binary
// square root of 64 steps, the bin multiply and a read-modify-write of the
// bin. The run ends with one result with run_done set.
// After reset the histogram is cleared by a sweep of all HIST_BINS bins
// during which no item is accepted; configuration writes are taken.
// A result waits in the output register while the receiver stalls; the
// block accepts no new item until that result is taken.
// Configuration and control registers reset; datapath registers do not.
module triclinic_pair_distance_histogram #(
  parameter int MAX_ATOMS = 1024,
  parameter int HIST_BINS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  atom_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [9:0]  read_bin_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  bin_number_o,
  output logic [31:0] bin_count_o,
  output logic [31:0] outside_count_o,
  output logic        run_done_o
);

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int BW = $clog2(HIST_BINS);
  localparam int CW = AW + 1;

  typedef enum logic [4:0] {
    StClear, StIdle, StRdWait, StRdOut, StOut,
    StPairInit, StPairRd, StPairRdWait, StDiff, StWrapYZ, StCorrX, StWrapX,
    StSqLoad, StSqMul, StSqAcc, StSqrt, StBinMul, StBinRd, StBinWait, StBinWr,
    StNext
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [30:0] len_x_q, len_y_q, len_z_q;
  logic signed [31:0] tilt_xy_q, tilt_xz_q, tilt_yz_q;
  logic [10:0] num_atoms_q;
  logic [23:0] bin_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_x_q <= 31'd655360;
      len_y_q <= 31'd655360;
      len_z_q <= 31'd655360;
      tilt_xy_q <= '0;
      tilt_xz_q <= '0;
      tilt_yz_q <= '0;
      num_atoms_q <= 11'd2;
      bin_scale_q <= 24'd655360;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tpdh_pkg::RegLenX:     len_x_q <= cfg_data_i[30:0];
        tpdh_pkg::RegLenY:     len_y_q <= cfg_data_i[30:0];
        tpdh_pkg::RegLenZ:     len_z_q <= cfg_data_i[30:0];
        tpdh_pkg::RegTiltXy:   tilt_xy_q <= cfg_data_i;
        tpdh_pkg::RegTiltXz:   tilt_xz_q <= cfg_data_i;
        tpdh_pkg::RegTiltYz:   tilt_yz_q <= cfg_data_i;
        tpdh_pkg::RegNumAtoms: num_atoms_q <= cfg_data_i[10:0];
        tpdh_pkg::RegBinScale: bin_scale_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Position memories.
  logic [31:0] mem_x [MAX_ATOMS];
  logic [31:0] mem_y [MAX_ATOMS];
  logic [31:0] mem_z [MAX_ATOMS];
  logic [AW-1:0] pos_raddr;
  logic [31:0] rd_x_q, rd_y_q, rd_z_q;
  logic pos_we;

  assign pos_we = (state_q == StIdle) && in_valid_i && (cmd_i == tpdh_pkg::CmdLoad)
                  && ({22'd0, atom_index_i} < 32'(MAX_ATOMS));

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      mem_x[AW'(atom_index_i)] <= pos_x_i;
      mem_y[AW'(atom_index_i)] <= pos_y_i;
      mem_z[AW'(atom_index_i)] <= pos_z_i;
    end
    rd_x_q <= mem_x[pos_raddr];
    rd_y_q <= mem_y[pos_raddr];
    rd_z_q <= mem_z[pos_raddr];
  end

  // Histogram memory: one write port, one registered read port.
  logic [31:0] hist_mem [HIST_BINS];
  logic [BW-1:0] h_raddr, h_waddr;
  logic [31:0] h_wdata, h_rdata_q;
  logic h_we;

  always_ff @(posedge clk_i) begin
    if (h_we) hist_mem[h_waddr] <= h_wdata;
    h_rdata_q <= hist_mem[h_raddr];
  end

  // Sequencer registers.
  logic [CW-1:0] i_q, j_q, n_q;
  logic [BW:0] sweep_q;
  logic [31:0] xi_q, yi_q, zi_q;
  logic signed [33:0] dx_q, dy_q, dz_q;
  logic signed [1:0] py_q, pz_q;
  logic [1:0] sq_sel_q, pp_q;
  logic [32:0] mag_q;
  logic [127:0] sum_q;
  logic [63:0] mul_q;
  logic [63:0] root_q;
  logic [65:0] rem_q;
  logic [5:0] step_q;
  logic [BW-1:0] bin_q;
  logic [32:0] bin_hi_q;
  logic outside_q;
  logic [31:0] outside_cnt_q;
  logic phase_q;  // high while the read loads atom i, at the first pair of each i
  logic [9:0] rd_bin_q;
  logic rd_oob_q;

  // Shared 32x32 multiplier.
  logic [31:0] mul_a, mul_b;
  assign mul_b = (state_q == StBinMul) ? {8'd0, bin_scale_q} : mag_q[31:0];
  always_comb begin
    mul_a = mag_q[31:0];
    if (state_q == StBinMul) mul_a = root_q[31:0];
    else if (pp_q[0]) mul_a = {31'd0, mag_q[32]};
    if (state_q == StSqMul && pp_q[1]) mul_a = {31'd0, mag_q[32]};
  end
  logic [31:0] mul_b2;
  assign mul_b2 = (state_q == StSqMul && pp_q == 2'd3) ? {31'd0, mag_q[32]} : mul_b;

  // Wrap factor: +1 if 2d >= L, -1 if 2d <= -L, else 0.
  function automatic logic signed [1:0] wrapf(input logic signed [33:0] d,
                                               input logic [30:0] l);
    logic signed [36:0] d2;
    logic signed [36:0] ll;
    begin
      d2 = 37'(d) <<< 1;
      ll = $signed({6'd0, l});
      if (d2 >= ll) wrapf = 2'sd1;
      else if (d2 <= -ll) wrapf = -2'sd1;
      else wrapf = 2'sd0;
    end
  endfunction

  logic signed [33:0] cur_d;
  assign cur_d = (sq_sel_q == 2'd0) ? dx_q : (sq_sel_q == 2'd1) ? dy_q : dz_q;

  logic [65:0] sq_trial;
  logic [65:0] sq_rem_sh;
  logic [1:0] sq_pair;
  assign sq_pair = sum_q[127:126];
  assign sq_rem_sh = {rem_q[63:0], sq_pair};
  assign sq_trial = {root_q, 2'b01};

  logic [CW-1:0] n_sat;
  assign n_sat = ({21'd0, num_atoms_q} > 32'(MAX_ATOMS)) ? CW'(MAX_ATOMS)
                 : CW'(num_atoms_q);

  // Full product of root and bin scale, then the fixed point shift.
  logic [72:0] bin_prod, bin_shift;
  assign bin_prod = {9'd0, mul_q} + {8'd0, bin_hi_q, 32'd0};
  assign bin_shift = bin_prod >> (2 * FRAC_BITS);

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    pos_raddr = phase_q ? i_q[AW-1:0] : j_q[AW-1:0];
    h_raddr = (state_q == StIdle) ? BW'(read_bin_i)
              : (state_q == StRdWait) ? BW'(rd_bin_q) : bin_q;
    h_we = 1'b0;
    h_waddr = bin_q;
    h_wdata = h_rdata_q + 32'd1;
    if (state_q == StClear) begin
      h_we = 1'b1;
      h_waddr = sweep_q[BW-1:0];
      h_wdata = '0;
    end else if (state_q == StBinWr) begin
      h_we = (h_rdata_q != tpdh_pkg::CountMax) && !outside_q;
    end
  end

  // Main sequencer with registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      sweep_q <= '0;
      out_valid_o <= 1'b0;
      outside_cnt_q <= '0;
      i_q <= '0;
      j_q <= '0;
      n_q <= '0;
      phase_q <= 1'b0;
      step_q <= '0;
      pp_q <= '0;
      sq_sel_q <= '0;
      bin_number_o <= '0;
      bin_count_o <= '0;
      outside_count_o <= '0;
      run_done_o <= 1'b0;
    end else begin
      case (state_q)
        StClear: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == (BW+1)'(HIST_BINS - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) begin
            case (cmd_i)
              tpdh_pkg::CmdLoad: state_q <= StNext;
              tpdh_pkg::CmdRun: begin
                n_q <= n_sat;
                i_q <= '0;
                state_q <= StPairInit;
              end
              tpdh_pkg::CmdRead: begin
                rd_bin_q <= read_bin_i;
                rd_oob_q <= ({22'd0, read_bin_i} >= 32'(HIST_BINS));
                state_q <= StRdWait;
              end
              default: begin
                sweep_q <= '0;
                outside_cnt_q <= '0;
                state_q <= StClear;
              end
            endcase
          end
        end
        StRdWait: state_q <= StRdOut;
        StRdOut: begin
          bin_number_o <= rd_bin_q;
          bin_count_o <= rd_oob_q ? 32'd0 : h_rdata_q;
          outside_count_o <= outside_cnt_q;
          run_done_o <= 1'b0;
          out_valid_o <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= StIdle;
          end
        end
        StPairInit: begin
          // Start the next i, or finish the run.
          if ({1'b0, i_q} + 1'b1 < {1'b0, n_q}) begin
            j_q <= i_q + 1'b1;
            phase_q <= 1'b1;
            state_q <= StPairRd;
          end else begin
            bin_number_o <= '0;
            bin_count_o <= '0;
            outside_count_o <= outside_cnt_q;
            run_done_o <= 1'b1;
            out_valid_o <= 1'b1;
            state_q <= StOut;
          end
        end
        StPairRd: state_q <= StPairRdWait;
        StPairRdWait: begin
          if (phase_q) begin
            xi_q <= rd_x_q;
            yi_q <= rd_y_q;
            zi_q <= rd_z_q;
            phase_q <= 1'b0;
            state_q <= StPairRd;
          end else begin
            state_q <= StDiff;
          end
        end
        StDiff: begin
          dx_q <= 34'($signed(xi_q)) - 34'($signed(rd_x_q));
          dy_q <= 34'($signed(yi_q)) - 34'($signed(rd_y_q));
          dz_q <= 34'($signed(zi_q)) - 34'($signed(rd_z_q));
          state_q <= StWrapYZ;
        end
        StWrapYZ: begin
          py_q <= wrapf(dy_q, len_y_q);
          pz_q <= wrapf(dz_q, len_z_q);
          state_q <= StCorrX;
        end
        StCorrX: begin
          // Tilt corrections and the z shift.
          dx_q <= dx_q - ((py_q == 2'sd1) ? 34'(tilt_xy_q) : (py_q == -2'sd1)
                  ? -34'(tilt_xy_q) : 34'sd0)
                       - ((pz_q == 2'sd1) ? 34'(tilt_xz_q) : (pz_q == -2'sd1)
                  ? -34'(tilt_xz_q) : 34'sd0);
          dy_q <= dy_q - ((pz_q == 2'sd1) ? 34'(tilt_yz_q) : (pz_q == -2'sd1)
                  ? -34'(tilt_yz_q) : 34'sd0);
          dz_q <= dz_q - ((pz_q == 2'sd1) ? $signed({3'd0, len_z_q})
                  : (pz_q == -2'sd1) ? -$signed({3'd0, len_z_q}) : 34'sd0);
          state_q <= StWrapX;
        end
        StWrapX: begin
          dx_q <= dx_q - ((wrapf(dx_q, len_x_q) == 2'sd1) ? $signed({3'd0, len_x_q})
                  : (wrapf(dx_q, len_x_q) == -2'sd1) ? -$signed({3'd0, len_x_q})
                  : 34'sd0);
          dy_q <= dy_q - ((wrapf(dy_q, len_y_q) == 2'sd1) ? $signed({3'd0, len_y_q})
                  : (wrapf(dy_q, len_y_q) == -2'sd1) ? -$signed({3'd0, len_y_q})
                  : 34'sd0);
          sum_q <= '0;
          sq_sel_q <= 2'd0;
          state_q <= StSqLoad;
        end
        StSqLoad: begin
          mag_q <= cur_d[33] ? 33'(-cur_d) : cur_d[32:0];
          pp_q <= 2'd0;
          state_q <= StSqMul;
        end
        StSqMul: begin
          // Partial products of mag*mag, with mag = h*2^32 + l, h one bit.
          mul_q <= 64'(mul_a) * 64'(mul_b2);
          state_q <= StSqAcc;
        end
        StSqAcc: begin
          case (pp_q)
            2'd0: sum_q <= sum_q + 128'(mul_q);
            2'd3: sum_q <= sum_q + (128'(mul_q) << 64);
            default: sum_q <= sum_q + (128'(mul_q) << 32);
          endcase
          pp_q <= pp_q + 1'b1;
          if (pp_q != 2'd3) begin
            state_q <= StSqMul;
          end else if (sq_sel_q != 2'd2) begin
            sq_sel_q <= sq_sel_q + 1'b1;
            state_q <= StSqLoad;
          end else begin
            root_q <= '0;
            rem_q <= '0;
            step_q <= '0;
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          // One bit of the floor square root per cycle.
          sum_q <= sum_q << 2;
          if (sq_rem_sh >= sq_trial) begin
            rem_q <= sq_rem_sh - sq_trial;
            root_q <= {root_q[62:0], 1'b1};
          end else begin
            rem_q <= sq_rem_sh;
            root_q <= {root_q[62:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == 6'd63) state_q <= StBinMul;
        end
        StBinMul: begin
          // The root is below 2^41; higher bits need a second product.
          mul_q <= 64'(mul_a) * 64'(mul_b);
          bin_hi_q <= 33'(root_q[40:32]) * 33'(bin_scale_q);
          state_q <= StBinRd;
        end
        StBinRd: begin
          outside_q <= (bin_shift >= 73'(HIST_BINS));
          bin_q <= BW'(bin_shift);
          state_q <= StBinWait;
        end
        StBinWait: state_q <= StBinWr;
        StBinWr: begin
          if (outside_q && outside_cnt_q != tpdh_pkg::CountMax)
            outside_cnt_q <= outside_cnt_q + 1'b1;
          state_q <= StNext;
        end
        StNext: begin
          if (phase_q == 1'b0 && state_q == StNext && i_q != j_q) begin
            if ({1'b0, j_q} + 1'b1 < {1'b0, n_q}) begin
              j_q <= j_q + 1'b1;
              phase_q <= 1'b0;
              state_q <= StPairRd;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= StPairInit;
            end
          end else begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (state_q == StIdle && in_valid_i && cmd_i == tpdh_pkg::CmdLoad) begin
        i_q <= '0;
        j_q <= '0;
      end
    end
  end

endmodule
